// ----- rtl/bmec_pkg.sv -----
package bmec_pkg;

	localparam int QueueDepthDef = 2;
	localparam int DivBits = 64;
	localparam int DenBits = 31;
	localparam int CfgIdxBits = 3;

	localparam logic [CfgIdxBits-1:0] CfgTemp = 3'd0;
	localparam logic [CfgIdxBits-1:0] CfgPressA = 3'd1;
	localparam logic [CfgIdxBits-1:0] CfgPressB = 3'd2;
	localparam logic [CfgIdxBits-1:0] CfgPressC = 3'd3;
	localparam logic [CfgIdxBits-1:0] CfgHum = 3'd4;

	localparam logic signed [27:0] PressTfOffset = 28'sd128000;
	localparam logic signed [27:0] HumTfOffset = 28'sd76800;
	localparam logic [20:0] PressBase = 21'd1048576;
	localparam logic [63:0] DivBias = 64'h0000_8000_0000_0000;
	localparam logic [63:0] NumScale = 64'd3125;
	localparam logic [31:0] HumRound = 32'd16384;
	localparam logic [31:0] HumOffsetC = 32'd32768;
	localparam logic [31:0] HumOffsetD = 32'd2097152;
	localparam logic [31:0] HumRoundE = 32'd8192;
	localparam logic [31:0] HumMax = 32'd419430400;

	typedef struct packed {
		logic [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic [7:0] h1;
		logic signed [15:0] h2;
		logic [7:0] h3;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0] h6;
	} cal_t;

	typedef struct packed {
		logic signed [26:0] tf;
		logic signed [26:0] temp;
		logic [19:0] adc_p;
		logic [15:0] adc_h;
	} item_t;

	typedef struct packed {
		logic signed [26:0] temp;
		logic [31:0] x;
		logic [31:0] sqm;
		logic neg;
		logic invalid;
	} div_side_t;

endpackage

// ----- rtl/bmec_front.sv -----
module bmec_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [19:0]          raw_temperature,
	input  logic [19:0]          raw_pressure,
	input  logic [15:0]          raw_humidity,
	input  bmec_pkg::cal_t       cal,
	output logic                 out_valid,
	output bmec_pkg::item_t      out_item
);

	logic                v_s1, v_s2, v_s3;
	logic signed [18:0]  d1_c;
	logic signed [16:0]  d2_c;
	logic signed [34:0]  d1t2_s1;
	logic signed [33:0]  d2sq_s1;
	logic signed [23:0]  a_s2;
	logic signed [36:0]  b_s2;
	logic signed [21:0]  d2sh_c;
	logic signed [26:0]  tf_c;
	logic signed [29:0]  t5_c;
	logic [19:0]         adc_p_s1, adc_p_s2;
	logic [15:0]         adc_h_s1, adc_h_s2;
	bmec_pkg::item_t     item_s3;

	assign d1_c = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
	assign d2_c = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
	assign d2sh_c = 22'(d2sq_s1 >>> 12);
	assign tf_c = 27'(a_s2) + 27'(b_s2 >>> 14);
	assign t5_c = 30'(tf_c) * 30'sd5 + 30'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		d1t2_s1 <= d1_c * cal.t2;
		d2sq_s1 <= d2_c * d2_c;
		adc_p_s1 <= raw_pressure;
		adc_h_s1 <= raw_humidity;
		a_s2 <= 24'(d1t2_s1 >>> 11);
		b_s2 <= d2sh_c * cal.t3;
		adc_p_s2 <= adc_p_s1;
		adc_h_s2 <= adc_h_s1;
		item_s3.tf <= tf_c;
		item_s3.temp <= 27'(t5_c >>> 8);
		item_s3.adc_p <= adc_p_s2;
		item_s3.adc_h <= adc_h_s2;
	end

	assign out_valid = v_s3;
	assign out_item = item_s3;

endmodule

// ----- rtl/bmec_fifo.sv -----
module bmec_fifo #(
	parameter int Depth = bmec_pkg::QueueDepthDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bmec_pkg::item_t push_item,
	input  logic            pop,
	output logic            not_empty,
	output logic            full,
	output bmec_pkg::item_t head_item
);

	localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CountBits = $clog2(Depth + 1);

	bmec_pkg::item_t        mem_q [Depth];
	logic [AddrBits-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CountBits-1:0]   count_q;
	logic                   do_pop;

	assign not_empty = count_q != '0;
	assign full = count_q == CountBits'(Depth);
	assign do_pop = pop && not_empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AddrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/bmec_div.sv -----
module bmec_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [bmec_pkg::DivBits-1:0]       in_num,
	input  logic [bmec_pkg::DenBits-1:0]       in_den,
	input  bmec_pkg::div_side_t                in_side,
	output logic                               out_valid,
	output logic [bmec_pkg::DivBits-1:0]       out_quo,
	output bmec_pkg::div_side_t                out_side
);

	localparam int N = bmec_pkg::DivBits;
	localparam int RW = bmec_pkg::DenBits + 1;

	logic                           vld_q  [N];
	logic [RW-1:0]                  rem_q  [N];
	logic [N-1:0]                   quo_q  [N];
	logic [bmec_pkg::DenBits-1:0]   den_q  [N];
	bmec_pkg::div_side_t            side_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                           vld_in;
		logic [RW-1:0]                  rem_in;
		logic [N-1:0]                   quo_in;
		logic [bmec_pkg::DenBits-1:0]   den_in;
		bmec_pkg::div_side_t            side_in;
		logic [RW-1:0]                  trial;
		logic                           ge;

		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign quo_in = in_num;
			assign den_in = in_den;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in = vld_q[k-1];
			assign rem_in = rem_q[k-1];
			assign quo_in = quo_q[k-1];
			assign den_in = den_q[k-1];
			assign side_in = side_q[k-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {rem_in[RW-2:0], quo_in[N-1]};
		assign ge = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else begin
				vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? trial - {1'b0, den_in} : trial;
			quo_q[k] <= {quo_in[N-2:0], ge};
			den_q[k] <= den_in;
			side_q[k] <= side_in;
		end
	end

	assign out_valid = vld_q[N-1];
	assign out_quo = quo_q[N-1];
	assign out_side = side_q[N-1];

endmodule

// ----- rtl/bmec_back.sv -----
module bmec_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  bmec_pkg::item_t  in_item,
	input  bmec_pkg::cal_t   cal,
	output logic             result_valid,
	output logic [26:0]      temperature_centi,
	output logic [31:0]      pressure_q24_8,
	output logic [16:0]      humidity_q22_10,
	output logic             pressure_invalid
);

	// pre-divide valids and post-divide valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_s7, v_s8, v_s9, v_s10, v_s11;
	logic res_valid_q;

	// stage 1
	logic signed [27:0]  a_c, u_c;
	logic signed [55:0]  aa_s1;
	logic signed [43:0]  ap5_s1, ap2_s1;
	logic signed [39:0]  h5u_c;
	logic signed [35:0]  uh6_c;
	logic signed [36:0]  uh3_c;
	logic [31:0]         h5u_s1, uh6_s1, uh3_s1;
	logic [19:0]         adc_p_s1, adc_p_s2, adc_p_s3;
	logic [15:0]         adc_h_s1;
	logic signed [26:0]  temp_s1, temp_s2, temp_s3, temp_s4, temp_s5;

	// stage 2
	logic signed [71:0]  aap6_c, aap3_c;
	logic signed [63:0]  aap6_s2, aap3_s2;
	logic signed [43:0]  ap5_s2, ap2_s2;
	logic [31:0]         hsum_c;
	logic [31:0]         ha_s2, ha_s3, ha_s4, hb_s2, hc_s2;

	// stage 3
	logic [63:0]         v2_s3, v1_s3;
	logic [31:0]         bc_s3;

	// stage 4
	logic [20:0]         base_c;
	logic [63:0]         dp_s4, n0_s4;
	logic [31:0]         hd_c, d2_s4;

	// stage 5
	logic signed [30:0]  div_s5;
	logic [63:0]         num_s5;
	logic [31:0]         he_c, x_s5;

	// stage 6
	logic [31:0]         xs_c;
	logic [63:0]         mag_n_s6;
	logic [30:0]         mag_d_s6;
	bmec_pkg::div_side_t side_s6;

	// divider output
	logic                dv_valid;
	logic [63:0]         dv_quo;
	bmec_pkg::div_side_t dv_side;

	// post stages
	logic [63:0]         q_s7, q_s8, q_s9, q_s10;
	logic [31:0]         x_s7, h1m_s7;
	logic                inv_s7, inv_s8, inv_s9, inv_s10, inv_s11;
	logic signed [26:0]  temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic [63:0]         ps_c;
	logic [63:0]         ll_s8, p8q_s8;
	logic [31:0]         hl_s8;
	logic [31:0]         hv_c;
	logic [16:0]         hum_s8, hum_s9, hum_s10, hum_s11;
	logic [63:0]         sq_s9, w2_s9, w2_s10, w1raw_s10;
	logic [63:0]         sum_c, r_s11;

	logic [26:0]         temp_q;
	logic [31:0]         pres_q;
	logic [16:0]         hum_q;
	logic                inv_q;

	// stage 1: offsets from fine temperature and first products
	assign a_c = 28'(in_item.tf) - bmec_pkg::PressTfOffset;
	assign u_c = 28'(in_item.tf) - bmec_pkg::HumTfOffset;
	assign h5u_c = cal.h5 * u_c;
	assign uh6_c = u_c * cal.h6;
	assign uh3_c = u_c * $signed({1'b0, cal.h3});

	always_ff @(posedge clk) begin
		aa_s1 <= a_c * a_c;
		ap5_s1 <= a_c * cal.p5;
		ap2_s1 <= a_c * cal.p2;
		h5u_s1 <= h5u_c[31:0];
		uh6_s1 <= uh6_c[31:0];
		uh3_s1 <= uh3_c[31:0];
		adc_p_s1 <= in_item.adc_p;
		adc_h_s1 <= in_item.adc_h;
		temp_s1 <= in_item.temp;
	end

	// stage 2
	assign aap6_c = aa_s1 * cal.p6;
	assign aap3_c = aa_s1 * cal.p3;
	assign hsum_c = {2'b00, adc_h_s1, 14'd0} - {cal.h4, 20'd0} - h5u_s1 + bmec_pkg::HumRound;

	always_ff @(posedge clk) begin
		aap6_s2 <= aap6_c[63:0];
		aap3_s2 <= aap3_c[63:0];
		ap5_s2 <= ap5_s1;
		ap2_s2 <= ap2_s1;
		ha_s2 <= 32'($signed(hsum_c) >>> 15);
		hb_s2 <= 32'($signed(uh6_s1) >>> 10);
		hc_s2 <= 32'($signed(uh3_s1) >>> 11) + bmec_pkg::HumOffsetC;
		adc_p_s2 <= adc_p_s1;
		temp_s2 <= temp_s1;
	end

	// stage 3
	always_ff @(posedge clk) begin
		v2_s3 <= 64'(aap6_s2) + (64'(ap5_s2) << 17) + (64'(cal.p4) << 35);
		v1_s3 <= 64'(aap3_s2 >>> 8) + (64'(ap2_s2) << 12);
		bc_s3 <= hb_s2 * hc_s2;
		ha_s3 <= ha_s2;
		adc_p_s3 <= adc_p_s2;
		temp_s3 <= temp_s2;
	end

	// stage 4
	assign base_c = bmec_pkg::PressBase - {1'b0, adc_p_s3};
	assign hd_c = 32'($signed(bc_s3) >>> 10) + bmec_pkg::HumOffsetD;

	always_ff @(posedge clk) begin
		dp_s4 <= (bmec_pkg::DivBias + v1_s3) * {48'd0, cal.p1};
		n0_s4 <= ({43'd0, base_c} << 31) - v2_s3;
		d2_s4 <= hd_c * 32'(cal.h2);
		ha_s4 <= ha_s3;
		temp_s4 <= temp_s3;
	end

	// stage 5
	assign he_c = 32'($signed(d2_s4 + bmec_pkg::HumRoundE) >>> 14);

	always_ff @(posedge clk) begin
		div_s5 <= $signed(dp_s4[63:33]);
		num_s5 <= n0_s4 * bmec_pkg::NumScale;
		x_s5 <= ha_s4 * he_c;
		temp_s5 <= temp_s4;
	end

	// stage 6: magnitudes for the unsigned divider
	assign xs_c = 32'($signed(x_s5) >>> 15);

	always_ff @(posedge clk) begin
		mag_n_s6 <= num_s5[63] ? (~num_s5 + 64'd1) : num_s5;
		mag_d_s6 <= div_s5[30] ? 31'(-div_s5) : 31'(div_s5);
		side_s6.neg <= num_s5[63] ^ div_s5[30];
		side_s6.invalid <= div_s5 == '0;
		side_s6.temp <= temp_s5;
		side_s6.x <= x_s5;
		side_s6.sqm <= xs_c * xs_c;
	end

	bmec_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_num    (mag_n_s6),
		.in_den    (mag_d_s6),
		.in_side   (side_s6),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// stage 7: restore quotient sign
	always_ff @(posedge clk) begin
		q_s7 <= dv_side.neg ? (~dv_quo + 64'd1) : dv_quo;
		h1m_s7 <= 32'($signed(dv_side.sqm) >>> 7) * {24'd0, cal.h1};
		x_s7 <= dv_side.x;
		inv_s7 <= dv_side.invalid;
		temp_s7 <= dv_side.temp;
	end

	// stage 8: square of the scaled quotient in 32-bit pieces
	assign ps_c = 64'($signed(q_s7) >>> 13);
	assign hv_c = x_s7 - 32'($signed(h1m_s7) >>> 4);

	always_ff @(posedge clk) begin
		ll_s8 <= {32'd0, ps_c[31:0]} * {32'd0, ps_c[31:0]};
		hl_s8 <= ps_c[63:32] * ps_c[31:0];
		p8q_s8 <= q_s7 * 64'(cal.p8);
		if (hv_c[31]) begin
			hum_s8 <= '0;
		end else if (hv_c > bmec_pkg::HumMax) begin
			hum_s8 <= bmec_pkg::HumMax[28:12];
		end else begin
			hum_s8 <= hv_c[28:12];
		end
		q_s8 <= q_s7;
		inv_s8 <= inv_s7;
		temp_s8 <= temp_s7;
	end

	// stage 9
	always_ff @(posedge clk) begin
		sq_s9 <= ll_s8 + {hl_s8[30:0], 33'd0};
		w2_s9 <= 64'($signed(p8q_s8) >>> 19);
		q_s9 <= q_s8;
		hum_s9 <= hum_s8;
		inv_s9 <= inv_s8;
		temp_s9 <= temp_s8;
	end

	// stage 10
	always_ff @(posedge clk) begin
		w1raw_s10 <= sq_s9 * 64'(cal.p9);
		w2_s10 <= w2_s9;
		q_s10 <= q_s9;
		hum_s10 <= hum_s9;
		inv_s10 <= inv_s9;
		temp_s10 <= temp_s9;
	end

	// stage 11
	assign sum_c = q_s10 + 64'($signed(w1raw_s10) >>> 25) + w2_s10;

	always_ff @(posedge clk) begin
		r_s11 <= 64'($signed(sum_c) >>> 8) + (64'(cal.p7) << 4);
		hum_s11 <= hum_s10;
		inv_s11 <= inv_s10;
		temp_s11 <= temp_s10;
	end

	// output register: saturate pressure
	always_ff @(posedge clk) begin
		temp_q <= temp_s11;
		hum_q <= hum_s11;
		inv_q <= inv_s11;
		if (inv_s11 || r_s11[63]) begin
			pres_q <= '0;
		end else if (r_s11[62:32] != '0) begin
			pres_q <= '1;
		end else begin
			pres_q <= r_s11[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= dv_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			res_valid_q <= v_s11;
		end
	end

	assign result_valid = res_valid_q;
	assign temperature_centi = temp_q;
	assign pressure_q24_8 = pres_q;
	assign humidity_q22_10 = hum_q;
	assign pressure_invalid = inv_q;

endmodule

// ----- rtl/bme280_compensation_core.sv -----
// Channel   | Signals                                            | Direction
// ----------+----------------------------------------------------+----------
// request   | start, busy, raw_temperature/pressure/humidity      | in
// result    | result_valid, temperature_centi, pressure_q24_8,   | out
//           | humidity_q22_10, pressure_invalid                  |
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data          | in
//
// One request per cycle while busy is low; each one passes in order through
// 3 front stages, 1 queue write, 6 pre-divide stages, 64 divider stages,
// 5 post stages and 1 output register. The 64-stage restoring divider sets
// the latency. Reset clears all valid flags and calibration registers.
// The receiver cannot stall; busy rises only if the queue fills.
module bme280_compensation_core #(
	parameter int QueueDepth = bmec_pkg::QueueDepthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [19:0]                     raw_temperature,
	input  logic [19:0]                     raw_pressure,
	input  logic [15:0]                     raw_humidity,
	output logic                            result_valid,
	output logic [26:0]                     temperature_centi,
	output logic [31:0]                     pressure_q24_8,
	output logic [16:0]                     humidity_q22_10,
	output logic                            pressure_invalid,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bmec_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);

	logic [47:0]      temp_cal_q;
	logic [63:0]      press_a_q, press_b_q, hum_cal_q;
	logic [15:0]      press_c_q;
	bmec_pkg::cal_t   cal;

	logic             accept;
	logic             front_valid;
	bmec_pkg::item_t  front_item;
	logic             q_not_empty, q_full;
	bmec_pkg::item_t  q_head;

	assign cfg_ready = 1'b1;
	assign accept = start && !busy;
	assign busy = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_c_q <= '0;
			hum_cal_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bmec_pkg::CfgTemp: temp_cal_q <= cfg_data[47:0];
				bmec_pkg::CfgPressA: press_a_q <= cfg_data;
				bmec_pkg::CfgPressB: press_b_q <= cfg_data;
				bmec_pkg::CfgPressC: press_c_q <= cfg_data[15:0];
				bmec_pkg::CfgHum: hum_cal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cal.t1 = temp_cal_q[15:0];
	assign cal.t2 = $signed(temp_cal_q[31:16]);
	assign cal.t3 = $signed(temp_cal_q[47:32]);
	assign cal.p1 = press_a_q[15:0];
	assign cal.p2 = $signed(press_a_q[31:16]);
	assign cal.p3 = $signed(press_a_q[47:32]);
	assign cal.p4 = $signed(press_a_q[63:48]);
	assign cal.p5 = $signed(press_b_q[15:0]);
	assign cal.p6 = $signed(press_b_q[31:16]);
	assign cal.p7 = $signed(press_b_q[47:32]);
	assign cal.p8 = $signed(press_b_q[63:48]);
	assign cal.p9 = $signed(press_c_q);
	assign cal.h1 = hum_cal_q[7:0];
	assign cal.h2 = $signed(hum_cal_q[23:8]);
	assign cal.h3 = hum_cal_q[31:24];
	assign cal.h4 = $signed(hum_cal_q[43:32]);
	assign cal.h5 = $signed(hum_cal_q[55:44]);
	assign cal.h6 = $signed(hum_cal_q[63:56]);

	bmec_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (accept),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.cal             (cal),
		.out_valid       (front_valid),
		.out_item        (front_item)
	);

	bmec_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_item (front_item),
		.pop       (1'b1),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head_item (q_head)
	);

	bmec_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (q_not_empty),
		.in_item           (q_head),
		.cal               (cal),
		.result_valid      (result_valid),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.humidity_q22_10   (humidity_q22_10),
		.pressure_invalid  (pressure_invalid)
	);

`ifndef ASSERT_OFF
	a_queue_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		!q_full) else $error("request queue filled up");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pressure_invalid |-> pressure_q24_8 == '0)
		else $error("invalid pressure not forced to zero");

	a_hum_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity above full scale");
`endif

endmodule
